@@ rtl/lmt_pkg.sv @@
// ----------------------------------------------------------------------------
// lmt_pkg
// Shared constants and types for the modular Lucas term unit.
// ----------------------------------------------------------------------------
package lmt_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int INDEX_WIDTH_DEF = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_P,
        ST_RED_Q,
        ST_TWO,
        ST_LOOP,
        ST_MAT,
        ST_SHIFT,
        ST_FIN_A,
        ST_FIN_B,
        ST_DONE
    } t_state;

    // handshake between sequencer and the shared multiply-reduce unit
    typedef struct packed {
        logic start;
    } t_mm_req;

    typedef struct packed {
        logic done;
    } t_mm_rsp;

endpackage

@@ rtl/lmt_if.sv @@
// ----------------------------------------------------------------------------
// lmt_if
// Valid/ready channels for the modular Lucas term unit.
// ----------------------------------------------------------------------------
interface lmt_in_if #(
    parameter int VW = 64,
    parameter int IW = 64
);
    logic              valid;
    logic              ready;
    logic [IW-1:0]     term_index;
    logic [VW-1:0]     param_p;
    logic [VW-1:0]     param_q;
    logic [VW-2:0]     modulus;

    modport source (output valid, term_index, param_p, param_q, modulus, input ready);
    modport sink   (input valid, term_index, param_p, param_q, modulus, output ready);
endinterface

interface lmt_out_if #(
    parameter int VW = 64
);
    logic              valid;
    logic              ready;
    logic [VW-2:0]     u_term;
    logic [VW-2:0]     v_term;

    modport source (output valid, u_term, v_term, input ready);
    modport sink   (input valid, u_term, v_term, output ready);
endinterface

@@ rtl/lmt_mulmod.sv @@
// ----------------------------------------------------------------------------
// lmt_mulmod
// Bit-serial modular multiply: x*y mod m, one bit of y per cycle, MSB first.
// x must be below m; y may be any W-bit value.
// ----------------------------------------------------------------------------
module lmt_mulmod
    import lmt_pkg::*;
#(
    parameter int W = VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mm_req       i_req,
    input  logic [W-2:0]  i_x,
    input  logic [W-1:0]  i_y,
    input  logic [W-2:0]  i_mod,
    output t_mm_rsp       o_rsp,
    output logic [W-2:0]  o_result
);

    localparam int MW = W - 1;
    localparam int CW = $clog2(W + 1);

    function automatic logic [MW-1:0] add_mod(input logic [MW-1:0] a,
                                               input logic [MW-1:0] b,
                                               input logic [MW-1:0] m);
        logic [MW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, m}) ? MW'(s - {1'b0, m}) : s[MW-1:0];
    endfunction

    logic [MW-1:0] r_acc, n_acc;
    logic [W-1:0]  r_y;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [MW-1:0] dbl;

    always_comb begin
        dbl   = add_mod(r_acc, r_acc, i_mod);
        n_acc = r_y[W-1] ? add_mod(dbl, i_x, i_mod) : dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_y   <= i_y;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[W-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_result   = r_acc;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running product");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != CW'(1)) |=> r_busy)
        else $error("product cut short");
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("running product with empty bit count");

endmodule

@@ rtl/modular_lucas_sequence_term_unit.sv @@
// ----------------------------------------------------------------------------
// modular_lucas_sequence_term_unit
// U_n(P,Q) mod m and V_n(P,Q) mod m by 2x2 matrix square-and-multiply.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. All products run on a single bit-serial
// multiply-reduce unit. An item costs three products for operand reduction,
// eight per matrix product (at most two matrix products per bit of n-1) and
// two for the final V term: roughly 5 + 16*bits(n-1) products. The input is
// ready only while no item is in flight; a finished result waits in the
// output register while the next item may be accepted.
module modular_lucas_sequence_term_unit
    import lmt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lmt_in_if.sink    i_in,
    lmt_out_if.source o_out
);

    localparam int W  = VALUE_WIDTH;
    localparam int MW = W - 1;

    function automatic logic [MW-1:0] add_mod(input logic [MW-1:0] a,
                                               input logic [MW-1:0] b,
                                               input logic [MW-1:0] m);
        logic [MW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, m}) ? MW'(s - {1'b0, m}) : s[MW-1:0];
    endfunction

    t_state r_state, n_state;

    logic [INDEX_WIDTH-1:0] r_e;
    logic          r_n_zero;
    logic [W-1:0]  r_p, r_q;
    logic [MW-1:0] r_m, r_one, r_two, r_pm, r_negq, r_tmp;
    logic [MW-1:0] r_acc_a, r_acc_b, r_acc_c, r_acc_d;
    logic [MW-1:0] r_bas_a, r_bas_b, r_bas_c, r_bas_d;
    logic [MW-1:0] r_new_a, r_new_b, r_new_c;
    logic [2:0]    r_k;
    logic          r_sq;
    logic          r_issued;
    logic          r_out_valid;
    logic [MW-1:0] r_out_u, r_out_v;

    t_mm_req       mm_req;
    t_mm_rsp       mm_rsp;
    logic [MW-1:0] mm_x, mm_res;
    logic [W-1:0]  mm_y;
    logic          work_st;
    logic [W-1:0]  p_mag, q_mag;
    logic [MW-1:0] mx_a, mx_b, mx_c, mx_d;
    logic [MW-1:0] sum_res, neg_res;

    assign p_mag   = r_p[W-1] ? (~r_p + 1'b1) : r_p;
    assign q_mag   = r_q[W-1] ? (~r_q + 1'b1) : r_q;
    assign sum_res = add_mod(r_tmp, mm_res, r_m);
    assign neg_res = (mm_res == '0) ? '0 : r_m - mm_res;

    assign work_st = (r_state == ST_RED_P) || (r_state == ST_RED_Q) ||
                     (r_state == ST_TWO) || (r_state == ST_MAT) ||
                     (r_state == ST_FIN_A) || (r_state == ST_FIN_B);
    assign mm_req.start = work_st && !r_issued;

    // left factor: acc for a multiply step, base when squaring
    always_comb begin
        mx_a = r_sq ? r_bas_a : r_acc_a;
        mx_b = r_sq ? r_bas_b : r_acc_b;
        mx_c = r_sq ? r_bas_c : r_acc_c;
        mx_d = r_sq ? r_bas_d : r_acc_d;
    end

    // k = {row, col, inner}
    always_comb begin
        mm_x = r_one;
        mm_y = '0;
        case (r_state)
            ST_RED_P: mm_y = p_mag;
            ST_RED_Q: mm_y = q_mag;
            ST_TWO:   mm_y = W'(2);
            ST_MAT: begin
                case ({r_k[2], r_k[0]})
                    2'b00:   mm_x = mx_a;
                    2'b01:   mm_x = mx_b;
                    2'b10:   mm_x = mx_c;
                    default: mm_x = mx_d;
                endcase
                case ({r_k[0], r_k[1]})
                    2'b00:   mm_y = {1'b0, r_bas_a};
                    2'b01:   mm_y = {1'b0, r_bas_b};
                    2'b10:   mm_y = {1'b0, r_bas_c};
                    default: mm_y = {1'b0, r_bas_d};
                endcase
            end
            ST_FIN_A: begin
                mm_x = r_acc_a;
                mm_y = {1'b0, r_pm};
            end
            ST_FIN_B: begin
                mm_x = r_acc_b;
                mm_y = {1'b0, r_two};
            end
            default: ;
        endcase
    end

    lmt_mulmod #(.W(W)) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mm_req),
        .i_x      (mm_x),
        .i_y      (mm_y),
        .i_mod    (r_m),
        .o_rsp    (mm_rsp),
        .o_result (mm_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.modulus == '0) ? ST_DONE : ST_RED_P;
                end
            end
            ST_RED_P: if (mm_rsp.done) n_state = ST_RED_Q;
            ST_RED_Q: if (mm_rsp.done) n_state = ST_TWO;
            ST_TWO: begin
                if (mm_rsp.done) n_state = r_n_zero ? ST_DONE : ST_LOOP;
            end
            ST_LOOP: begin
                if (r_e == '0)   n_state = ST_FIN_A;
                else if (r_e[0]) n_state = ST_MAT;
                else             n_state = ST_SHIFT;
            end
            ST_MAT: begin
                if (mm_rsp.done && r_k == 3'd7) n_state = r_sq ? ST_LOOP : ST_SHIFT;
            end
            ST_SHIFT: n_state = ((r_e >> 1) != '0) ? ST_MAT : ST_LOOP;
            ST_FIN_A: if (mm_rsp.done) n_state = ST_FIN_B;
            ST_FIN_B: if (mm_rsp.done) n_state = ST_DONE;
            ST_DONE:  if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mm_req.start)     r_issued <= 1'b1;
            else if (mm_rsp.done) r_issued <= 1'b0;
            if (r_state == ST_DONE && n_state == ST_IDLE) r_out_valid <= 1'b1;
            else if (o_out.ready)                         r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_p      <= i_in.param_p;
                r_q      <= i_in.param_q;
                r_m      <= i_in.modulus;
                r_one    <= (i_in.modulus == MW'(1)) ? '0 : MW'(1);
                r_e      <= i_in.term_index - 1'b1;
                r_n_zero <= (i_in.term_index == '0);
                r_acc_a  <= '0;
                r_tmp    <= '0;
                r_k      <= '0;
                r_sq     <= 1'b0;
            end
            ST_RED_P: if (mm_rsp.done) r_pm <= r_p[W-1] ? neg_res : mm_res;
            ST_RED_Q: if (mm_rsp.done) r_negq <= r_q[W-1] ? mm_res : neg_res;
            ST_TWO: begin
                if (mm_rsp.done) begin
                    r_two   <= mm_res;
                    r_tmp   <= mm_res;
                    // n of zero: U is 0, V is 2 mod m; straight to the output
                    r_acc_a <= r_n_zero ? '0 : r_one;
                    r_acc_b <= '0;
                    r_acc_c <= '0;
                    r_acc_d <= r_one;
                    r_bas_a <= r_pm;
                    r_bas_b <= r_negq;
                    r_bas_c <= r_one;
                    r_bas_d <= '0;
                end
            end
            ST_LOOP: begin
                r_k  <= '0;
                r_sq <= 1'b0;
            end
            ST_MAT: begin
                if (mm_rsp.done) begin
                    r_k <= r_k + 1'b1;
                    if (!r_k[0]) begin
                        r_tmp <= mm_res;
                    end else begin
                        case (r_k[2:1])
                            2'b00: r_new_a <= sum_res;
                            2'b01: r_new_b <= sum_res;
                            2'b10: r_new_c <= sum_res;
                            default: begin
                                if (r_sq) begin
                                    r_bas_a <= r_new_a;
                                    r_bas_b <= r_new_b;
                                    r_bas_c <= r_new_c;
                                    r_bas_d <= sum_res;
                                end else begin
                                    r_acc_a <= r_new_a;
                                    r_acc_b <= r_new_b;
                                    r_acc_c <= r_new_c;
                                    r_acc_d <= sum_res;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_SHIFT: begin
                r_e  <= r_e >> 1;
                r_k  <= '0;
                r_sq <= 1'b1;
            end
            ST_FIN_A: if (mm_rsp.done) r_tmp <= mm_res;
            ST_FIN_B: if (mm_rsp.done) r_tmp <= sum_res;
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    r_out_u <= r_acc_a;
                    r_out_v <= r_tmp;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready   = (r_state == ST_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.u_term = r_out_u;
    assign o_out.v_term = r_out_v;

    a_done_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_rsp.done |-> work_st)
        else $error("product result outside a work state");
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && n_state == ST_IDLE) |=> o_out.valid)
        else $error("finished item not presented");
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOP) |-> (r_acc_a < r_m && r_bas_a < r_m && r_bas_b < r_m))
        else $error("matrix entry not reduced");

endmodule
